// File: rtl/lzsd_pkg.sv
package lzsd_pkg;

  localparam int SIZE_BITS      = 24;
  localparam int WINDOW_DEPTH   = 2048;
  localparam int WIN_BITS       = $clog2(WINDOW_DEPTH);
  localparam int LEN_BITS       = 5;
  localparam int BYTE_BITS      = 8;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  // copy length is COPY_LEN_BASE minus header bits 6..3
  localparam logic [LEN_BITS-1:0]  COPY_LEN_BASE = LEN_BITS'(16);
  localparam logic [BYTE_BITS-1:0] LIT_RUN_MAX   = BYTE_BITS'(128);

  // configuration port
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam logic REG_OUTPUT_SIZE = 1'b0;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_LIT_OVERRUN  = 2'd1,
    ST_BAD_OFFSET   = 2'd2,
    ST_COPY_OVERRUN = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_LIT   = 2'd0,
    CMD_COPY  = 2'd1,
    CMD_FAULT = 2'd2
  } cmd_kind_t;

  // data holds the literal byte or the back-offset
  typedef struct packed {
    cmd_kind_t             kind;
    logic [WIN_BITS-1:0]   data;
    logic [LEN_BITS-1:0]   len;
    logic                  done;
    status_t               code;
  } cmd_t;

endpackage

// File: rtl/lzsd_front.sv
module lzsd_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [lzsd_pkg::BYTE_BITS-1:0] in_byte,
  input  logic                           in_first,
  input  logic [lzsd_pkg::SIZE_BITS-1:0] output_size,
  input  logic                           queue_full,
  output logic                           push,
  output lzsd_pkg::cmd_t                 cmd
);
  import lzsd_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_LITERAL = 3'b010,
    PH_OFFSET  = 3'b100
  } phase_t;

  phase_t                phase, phase_next, eff_phase;
  logic [SIZE_BITS-1:0]  produced, produced_next, eff_produced;
  logic [SIZE_BITS-1:0]  remaining, remaining_next, eff_rem;
  logic [BYTE_BITS-1:0]  held, held_next, eff_held;
  logic [BYTE_BITS-1:0]  lit_left, lit_left_next, eff_lit;
  logic                  fault, fault_next, eff_fault;

  logic                  accept;
  logic [WIN_BITS-1:0]   offset;
  logic [LEN_BITS-1:0]   copy_len;
  logic [BYTE_BITS-1:0]  lit_len;
  logic [SIZE_BITS-1:0]  rem_minus_copy;
  logic [SIZE_BITS-1:0]  rem_minus_lit;

  assign in_ready = !queue_full;
  assign accept   = in_valid && !queue_full;

  // a first item clears the image state before it is parsed
  assign eff_phase    = in_first ? PH_HEADER : phase;
  assign eff_produced = in_first ? '0 : produced;
  assign eff_rem      = in_first ? output_size : remaining;
  assign eff_held     = in_first ? '0 : held;
  assign eff_lit      = in_first ? '0 : lit_left;
  assign eff_fault    = in_first ? 1'b0 : fault;

  assign offset         = {eff_held[2:0], in_byte};
  assign copy_len       = COPY_LEN_BASE - {1'b0, eff_held[6:3]};
  assign lit_len        = (in_byte == '0) ? LIT_RUN_MAX : in_byte;
  assign rem_minus_copy = eff_rem - SIZE_BITS'(copy_len);
  assign rem_minus_lit  = eff_rem - SIZE_BITS'(lit_len);

  always_comb begin
    phase_next     = phase;
    produced_next  = produced;
    remaining_next = remaining;
    held_next      = held;
    lit_left_next  = lit_left;
    fault_next     = fault;
    push           = 1'b0;
    cmd            = '0;
    if (accept) begin
      phase_next     = eff_phase;
      produced_next  = eff_produced;
      remaining_next = eff_rem;
      held_next      = eff_held;
      lit_left_next  = eff_lit;
      fault_next     = eff_fault;
      if (!eff_fault) begin
        case (eff_phase)
          PH_LITERAL: begin
            push          = 1'b1;
            cmd.kind      = CMD_LIT;
            cmd.data      = WIN_BITS'(in_byte);
            cmd.done      = (eff_lit == BYTE_BITS'(1)) && (eff_rem == '0);
            cmd.code      = ST_OK;
            produced_next = eff_produced + SIZE_BITS'(1);
            lit_left_next = eff_lit - BYTE_BITS'(1);
            if (eff_lit == BYTE_BITS'(1)) begin
              phase_next = PH_HEADER;
            end
          end
          PH_OFFSET: begin
            phase_next = PH_HEADER;
            push       = 1'b1;
            if (offset == '0 || SIZE_BITS'(offset) > eff_produced) begin
              cmd.kind      = CMD_FAULT;
              cmd.code      = ST_BAD_OFFSET;
              fault_next    = 1'b1;
              lit_left_next = '0;
            end else if (eff_rem < SIZE_BITS'(copy_len)) begin
              cmd.kind      = CMD_FAULT;
              cmd.code      = ST_COPY_OVERRUN;
              fault_next    = 1'b1;
              lit_left_next = '0;
            end else begin
              cmd.kind       = CMD_COPY;
              cmd.data       = offset;
              cmd.len        = copy_len;
              cmd.done       = (rem_minus_copy == '0);
              cmd.code       = ST_OK;
              remaining_next = rem_minus_copy;
              produced_next  = eff_produced + SIZE_BITS'(copy_len);
            end
          end
          default: begin
            // header; an image with nothing left ignores it
            phase_next = PH_HEADER;
            if (eff_rem != '0) begin
              if (!in_byte[7]) begin
                if (eff_rem < SIZE_BITS'(lit_len)) begin
                  push          = 1'b1;
                  cmd.kind      = CMD_FAULT;
                  cmd.code      = ST_LIT_OVERRUN;
                  fault_next    = 1'b1;
                  lit_left_next = '0;
                end else begin
                  remaining_next = rem_minus_lit;
                  lit_left_next  = lit_len;
                  phase_next     = PH_LITERAL;
                end
              end else begin
                held_next  = in_byte;
                phase_next = PH_OFFSET;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      produced  <= '0;
      remaining <= '0;
      held      <= '0;
      lit_left  <= '0;
      fault     <= 1'b0;
    end else begin
      phase     <= phase_next;
      produced  <= produced_next;
      remaining <= remaining_next;
      held      <= held_next;
      lit_left  <= lit_left_next;
      fault     <= fault_next;
    end
  end

endmodule

// File: rtl/lzsd_fifo.sv
module lzsd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lzsd_pkg::cmd_t wr_cmd,
  input  logic           pop,
  output lzsd_pkg::cmd_t rd_cmd,
  output logic           empty,
  output logic           full
);
  import lzsd_pkg::*;

  cmd_t                      entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_PTR_BITS:0]   count;
  logic                      do_push, do_pop;

  assign empty   = (count == '0);
  assign full    = (count == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_BITS'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (QUEUE_PTR_BITS+1)'(1);
        2'b01:   count <= count - (QUEUE_PTR_BITS+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/lzsd_back.sv
module lzsd_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_empty,
  input  lzsd_pkg::cmd_t                 q_cmd,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lzsd_pkg::BYTE_BITS-1:0] out_byte,
  output logic                           out_last,
  output logic                           out_done,
  output lzsd_pkg::status_t              out_status
);
  import lzsd_pkg::*;

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_COPY = 2'b10
  } back_state_t;

  back_state_t           state, state_next;
  logic [WIN_BITS-1:0]   wr_ptr, wr_ptr_next;
  logic [WIN_BITS-1:0]   src_ptr, src_ptr_next;
  logic [LEN_BITS-1:0]   cnt, cnt_next;
  logic                  copy_done, copy_done_next;

  logic [BYTE_BITS-1:0]  history [WINDOW_DEPTH];
  logic [BYTE_BITS-1:0]  rd_q;
  logic                  mem_we, rd_en;
  logic [BYTE_BITS-1:0]  mem_wd;
  logic [WIN_BITS-1:0]   rd_addr;

  logic                  load_ok, out_load;
  logic [BYTE_BITS-1:0]  ld_byte;
  logic                  ld_last, ld_done;
  status_t               ld_status;

  assign load_ok = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    wr_ptr_next    = wr_ptr;
    src_ptr_next   = src_ptr;
    cnt_next       = cnt;
    copy_done_next = copy_done;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    mem_wd         = '0;
    rd_en          = 1'b0;
    rd_addr        = src_ptr;
    out_load       = 1'b0;
    ld_byte        = '0;
    ld_last        = 1'b0;
    ld_done        = 1'b0;
    ld_status      = ST_OK;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          case (q_cmd.kind)
            CMD_LIT: begin
              if (load_ok) begin
                q_pop       = 1'b1;
                mem_we      = 1'b1;
                mem_wd      = q_cmd.data[BYTE_BITS-1:0];
                out_load    = 1'b1;
                ld_byte     = q_cmd.data[BYTE_BITS-1:0];
                ld_last     = 1'b1;
                ld_done     = q_cmd.done;
                wr_ptr_next = wr_ptr + WIN_BITS'(1);
              end
            end
            CMD_COPY: begin
              q_pop          = 1'b1;
              rd_en          = 1'b1;
              rd_addr        = wr_ptr - q_cmd.data;
              src_ptr_next   = rd_addr + WIN_BITS'(1);
              cnt_next       = q_cmd.len;
              copy_done_next = q_cmd.done;
              state_next     = BK_COPY;
            end
            CMD_FAULT: begin
              if (load_ok) begin
                q_pop     = 1'b1;
                out_load  = 1'b1;
                ld_last   = 1'b1;
                ld_status = q_cmd.code;
              end
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      BK_COPY: begin
        // rd_q holds the byte for this step; the next read may hit the byte
        // written now (offset of one), which the memory forwards
        if (load_ok) begin
          mem_we      = 1'b1;
          mem_wd      = rd_q;
          out_load    = 1'b1;
          ld_byte     = rd_q;
          ld_last     = (cnt == LEN_BITS'(1));
          ld_done     = (cnt == LEN_BITS'(1)) && copy_done;
          wr_ptr_next = wr_ptr + WIN_BITS'(1);
          cnt_next    = cnt - LEN_BITS'(1);
          if (cnt == LEN_BITS'(1)) begin
            state_next = BK_IDLE;
          end else begin
            rd_en        = 1'b1;
            rd_addr      = src_ptr;
            src_ptr_next = src_ptr + WIN_BITS'(1);
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      history[wr_ptr] <= mem_wd;
    end
    if (rd_en) begin
      rd_q <= (mem_we && rd_addr == wr_ptr) ? mem_wd : history[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      wr_ptr    <= '0;
      src_ptr   <= '0;
      cnt       <= '0;
      copy_done <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      wr_ptr    <= wr_ptr_next;
      src_ptr   <= src_ptr_next;
      cnt       <= cnt_next;
      copy_done <= copy_done_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte   <= ld_byte;
      out_last   <= ld_last;
      out_done   <= ld_done;
      out_status <= ld_status;
    end
  end

  a_no_pop_in_copy: assert property (@(posedge clk) disable iff (rst)
    state == BK_COPY |-> !q_pop)
    else $error("queue popped during copy");

  a_copy_count_live: assert property (@(posedge clk) disable iff (rst)
    state == BK_COPY |-> cnt != '0)
    else $error("copy state with no bytes left");

  a_fault_result_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_OK |-> out_byte == '0 && out_last && !out_done)
    else $error("malformed fault result");

  a_copy_ends_on_last: assert property (@(posedge clk) disable iff (rst)
    state == BK_COPY && out_load && cnt == LEN_BITS'(1) |=> state == BK_IDLE && out_last)
    else $error("copy did not end with its last byte");

endmodule

// File: rtl/lz_sprite_decompressor.sv
// A literal byte passes through the command queue and the output register before it
// appears on m_*; the first byte of a back-reference also waits on a history memory read.
// Throughput: one input per cycle while the 4-entry command queue has room; the
// back end emits one byte per cycle while m_tready allows, and a copy starts with a
// history memory read ahead before its first byte.
// Reset: synchronous, clears counters, parser, queue and output valid; history is not cleared.
module lz_sprite_decompressor (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lzsd_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [lzsd_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [lzsd_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,  // [7:0] in_byte
  input  logic [0:0]                         s_tuser,  // [0] first
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [7:0]                         m_tdata,  // [7:0] out_byte
  output logic                               m_tlast,  // run_last
  output logic [2:0]                         m_tuser   // [0] done_res, [2:1] status
);
  import lzsd_pkg::*;

  logic [SIZE_BITS-1:0] output_size;
  logic                 reg_sel;
  logic                 push, pop, q_empty, q_full;
  cmd_t                 push_cmd, head_cmd;
  logic                 out_done;
  status_t              out_status;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_ADDR_BITS-1] == REG_OUTPUT_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      output_size <= '0;
    end else if (psel && penable && pwrite && reg_sel) begin
      output_size <= pwdata[SIZE_BITS-1:0];
    end
  end

  assign prdata = reg_sel ? APB_DATA_BITS'(output_size) : '0;

  lzsd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_byte     (s_tdata),
    .in_first    (s_tuser[0]),
    .output_size (output_size),
    .queue_full  (q_full),
    .push        (push),
    .cmd         (push_cmd)
  );

  lzsd_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (push_cmd),
    .pop    (pop),
    .rd_cmd (head_cmd),
    .empty  (q_empty),
    .full   (q_full)
  );

  lzsd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_cmd      (head_cmd),
    .q_pop      (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (m_tdata),
    .out_last   (m_tlast),
    .out_done   (out_done),
    .out_status (out_status)
  );

  assign m_tuser = {out_status, out_done};

endmodule
